/* hdl/min_priority_queue_array_macros.svh */
// Assertion macros used by the queue top level.
`ifndef MIN_PRIORITY_QUEUE_ARRAY_MACROS_SVH
`define MIN_PRIORITY_QUEUE_ARRAY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/mpq_pkg.sv */
// Package with types, codes and sizes for the minimum-first priority queue.
package mpq_pkg;

  // Store geometry.
  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int HELD_W  = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  // Command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One command item.
  typedef struct packed {
    logic [1:0]                command;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] min_value;
    logic [COUNT_W-1:0]        count;
  } out_item_t;

  // Control that travels with each read returning from the store.
  typedef struct packed {
    logic              valid;
    logic              first;
    logic [ADDR_W-1:0] idx;
  } scan_ctl_t;

  // The reported count is the low bits of the fill level.
  function automatic logic [COUNT_W-1:0] to_count(input logic [HELD_W-1:0] h);
    return COUNT_W'(h);
  endfunction

endpackage

/* hdl/mpq_ram.sv */
// Generic single-write, single-read memory with registered read data.
module mpq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/mpq_min_scan.sv */
// Running minimum over the stream of entries read back from the store.
module mpq_min_scan (
  input  logic                              clk,
  input  mpq_pkg::scan_ctl_t                ctl,
  input  logic signed [mpq_pkg::VALUE_W-1:0] data,
  output logic signed [mpq_pkg::VALUE_W-1:0] best_val,
  output logic [mpq_pkg::ADDR_W-1:0]        best_idx,
  output logic signed [mpq_pkg::VALUE_W-1:0] last_val
);
  import mpq_pkg::*;

  // Keep the first smallest entry; a later equal one does not replace it.
  // The last entry seen is kept to fill the hole left by a delete.
  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      if (ctl.first || (data < best_val)) begin
        best_val <= data;
        best_idx <= ctl.idx;
      end
      last_val <= data;
    end
  end

endmodule

/* hdl/min_priority_queue_array.sv */
// Top level of the minimum-first priority queue over an on-chip store.
//
//   Channel   Ports               Handshake
//   command   start, busy, item   taken at an edge with start high, busy low
//   result    done, result        valid for one cycle while done is high
//
// Insert, and any command that finds the store full or empty, gives its result
// in the cycle after it is taken. Delete and peek read every held entry
// through the single read port of the store, one per cycle, and give the result
// after the scan, drain and finish states. Reset is synchronous and empties the
// queue; the store itself is not cleared. Results cannot be stalled, and a new
// command may be taken in the same cycle that a result is shown.
module min_priority_queue_array (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mpq_pkg::in_item_t  item,
  output logic               done,
  output mpq_pkg::out_item_t result
);
  import mpq_pkg::*;

  `include "min_priority_queue_array_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t             state;
  logic               is_delete;
  logic [HELD_W-1:0]  held;
  logic [ADDR_W-1:0]  cnt;
  scan_ctl_t          pipe;
  logic               accept;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [VALUE_W-1:0] wdata;
  logic               re;
  logic [VALUE_W-1:0] rdata;

  logic signed [VALUE_W-1:0] best_val;
  logic [ADDR_W-1:0]         best_idx;
  logic signed [VALUE_W-1:0] last_val;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Store write: append on insert, or move the last entry into the slot of
  // the removed minimum. Reads only happen while scanning, so they never
  // overlap a write.
  always_comb begin
    we    = 1'b0;
    waddr = ADDR_W'(held);
    wdata = item.value;
    if (accept && (item.command == CMD_INSERT) && (held < HELD_W'(DEPTH))) begin
      we = 1'b1;
    end else if ((state == S_FINISH) && is_delete) begin
      we    = 1'b1;
      waddr = best_idx;
      wdata = last_val;
    end
  end

  assign re = (state == S_SCAN);

  mpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(cnt),
    .rdata(rdata)
  );

  mpq_min_scan u_scan (
    .clk     (clk),
    .ctl     (pipe),
    .data    (rdata),
    .best_val(best_val),
    .best_idx(best_idx),
    .last_val(last_val)
  );

  // Command sequencer with the fill level and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held       <= '0;
      cnt        <= '0;
      pipe.valid <= 1'b0;
      done       <= 1'b0;
      is_delete  <= 1'b0;
    end else begin
      done       <= 1'b0;
      pipe.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            result.min_value <= '0;
            result.status    <= ST_OK;
            result.count     <= to_count(held);
            cnt              <= '0;
            is_delete        <= (item.command == CMD_DELETE);
            case (item.command)
              CMD_INSERT: begin
                done <= 1'b1;
                if (held < HELD_W'(DEPTH)) begin
                  held         <= held + HELD_W'(1);
                  result.count <= to_count(held + HELD_W'(1));
                end else begin
                  result.status <= ST_FULL;
                end
              end
              CMD_DELETE, CMD_PEEK: begin
                if (held == '0) begin
                  done          <= 1'b1;
                  result.status <= ST_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Issue one read per cycle; the control follows the read data.
          pipe.valid <= 1'b1;
          pipe.first <= (cnt == '0);
          pipe.idx   <= cnt;
          if (HELD_W'(cnt) == held - HELD_W'(1)) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        S_DRAIN: begin
          // The last entry is taken in by the scan during this cycle.
          state <= S_FINISH;
        end
        S_FINISH: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (is_delete) begin
            held         <= held - HELD_W'(1);
            result.count <= to_count(held - HELD_W'(1));
          end else begin
            result.min_value <= best_val;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on sequencing and fill level.
  `MPQ_ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")
  `MPQ_ASSERT_SAME(a_held_bound, 1'b1, held <= HELD_W'(DEPTH), "fill level beyond depth")
  `MPQ_ASSERT_NEXT(a_accept_progress, accept, done || busy, "accepted item dropped")
  `MPQ_ASSERT_SAME(a_full_level, done && (result.status == ST_FULL),
                   held == HELD_W'(DEPTH), "full status below depth")

endmodule

/* tb/sv/min_priority_queue_array_tb.sv */
// Self-checking testbench for the minimum-first priority queue.
`timescale 1ns / 1ps

module min_priority_queue_array_tb;
  import mpq_pkg::*;

  // Command code that the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Run limit in clock cycles, several times the slowest correct run.
  localparam int CYCLE_LIMIT = 750_000;

  // Settle time at the end: a full-store scan plus margin.
  localparam int SETTLE_CYCLES = DEPTH + 8;

  // Item mixes for the random part.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  item;
  logic      done;
  out_item_t result;

  // Shadow copy of the store and the results still owed by the block.
  logic signed [VALUE_W-1:0] shadow_entries[$];
  out_item_t                 pending_results[$];

  int  failures;
  int  cycle_count;
  bit  idle_on;

  min_priority_queue_array u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Index of the first smallest entry in the shadow store, which must not be empty.
  function automatic int first_min_index();
    int best;
    best = 0;
    for (int i = 1; i < shadow_entries.size(); i++) begin
      if (shadow_entries[i] < shadow_entries[best]) begin
        best = i;
      end
    end
    return best;
  endfunction

  // Apply one accepted command to the shadow store and return the result it gives.
  function automatic out_item_t queue_result(input in_item_t cmd_item);
    out_item_t r;
    r = '0;
    r.status = ST_OK;
    case (cmd_item.command)
      CMD_INSERT: begin
        if (shadow_entries.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries.push_back(cmd_item.value);
        end
      end
      CMD_DELETE: begin
        if (shadow_entries.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_entries.delete(first_min_index());
        end
      end
      CMD_PEEK: begin
        if (shadow_entries.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.min_value = shadow_entries[first_min_index()];
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(shadow_entries.size());
    return r;
  endfunction

  // Values lean toward the extremes and toward a narrow band that gives duplicates.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'sh7fff_ffff;
      1: v = 32'sh8000_0000;
      2, 3: v = $signed($urandom_range(0, 8)) - 4;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Send one item: when idle_on is set, idle for a random gap, then hold start until the block takes it.
  task automatic send_item(input logic [1:0] cmd, input logic signed [VALUE_W-1:0] val);
    int       gap;
    in_item_t cmd_item;
    in_item_t junk;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    cmd_item.command = cmd;
    cmd_item.value = val;
    repeat (gap) begin
      @(negedge clk);
      junk.command = 2'($urandom());
      junk.value = $urandom();
      start <= 1'b0;
      item <= junk;
    end
    @(negedge clk);
    start <= 1'b1;
    item <= cmd_item;
    do @(posedge clk); while (busy);
    pending_results.push_back(queue_result(cmd_item));
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Delete until the shadow store is empty.
  task automatic empty_queue();
    while (shadow_entries.size() != 0) send_item(CMD_DELETE, pick_value());
  endtask

  // Delete, peek and the unused code on an empty queue.
  task automatic test_empty_queue();
    send_item(CMD_DELETE, $urandom());
    send_item(CMD_PEEK, $urandom());
    send_item(CMD_UNUSED, $urandom());
  endtask

  // The most positive and most negative values, zero and minus one.
  task automatic test_value_extremes();
    send_item(CMD_INSERT, 32'sh7fff_ffff);
    send_item(CMD_PEEK, 32'sh0);
    send_item(CMD_INSERT, 32'sh8000_0000);
    send_item(CMD_PEEK, 32'sh7fff_ffff);
    send_item(CMD_INSERT, 32'sh0);
    send_item(CMD_INSERT, -32'sh1);
    send_item(CMD_UNUSED, 32'sh8000_0000);
    send_item(CMD_DELETE, -32'sh1);
    send_item(CMD_PEEK, 32'sh0);
    send_item(CMD_DELETE, 32'sh0);
    send_item(CMD_DELETE, 32'sh0);
    send_item(CMD_PEEK, 32'sh0);
    send_item(CMD_DELETE, 32'sh0);
  endtask

  // Several equal minima mixed with larger values.
  task automatic test_equal_minima();
    send_item(CMD_INSERT, 32'sd7);
    send_item(CMD_INSERT, -32'sd3);
    send_item(CMD_INSERT, -32'sd3);
    send_item(CMD_INSERT, -32'sd3);
    send_item(CMD_DELETE, 32'sd0);
    send_item(CMD_PEEK, 32'sd0);
    send_item(CMD_DELETE, 32'sd0);
    send_item(CMD_DELETE, 32'sd0);
    send_item(CMD_PEEK, 32'sd0);
  endtask

  // Fill the store, insert into a full store, then drain it again.
  task automatic test_full_store();
    empty_queue();
    while (shadow_entries.size() < DEPTH) send_item(CMD_INSERT, pick_value());
    send_item(CMD_INSERT, pick_value());
    send_item(CMD_PEEK, pick_value());
    send_item(CMD_INSERT, pick_value());
    send_item(CMD_UNUSED, pick_value());
    empty_queue();
  endtask

  // Random command streams in phases that fill, drain or hold the queue level.
  task automatic test_random_mix(input int num_items);
    int         sent;
    int         phase_left;
    int         roll;
    mix_t       mix;
    logic [1:0] cmd;
    sent = 0;
    phase_left = 0;
    mix = MIX_BALANCED;
    while (sent < num_items) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 80);
        mix = mix_t'($urandom_range(0, 2));
        idle_on = ($urandom_range(0, 3) != 0);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        cmd = CMD_UNUSED;
      end else begin
        case (mix)
          MIX_FILL:  cmd = (roll < 77) ? CMD_INSERT : (roll < 90) ? CMD_DELETE : CMD_PEEK;
          MIX_DRAIN: cmd = (roll < 17) ? CMD_INSERT : (roll < 80) ? CMD_DELETE : CMD_PEEK;
          default:   cmd = (roll < 42) ? CMD_INSERT : (roll < 75) ? CMD_DELETE : CMD_PEEK;
        endcase
      end
      send_item(cmd, pick_value());
      if (cmd != CMD_UNUSED) sent++;
      // Now and then let the block run dry before the next item.
      if ($urandom_range(0, 149) == 0) wait_drained();
    end
  endtask

  // Compare each result with the oldest owed one.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no command pending: status %0d min_value %0d count %0d",
               result.status, result.min_value, result.count);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, result.status);
          failures++;
        end
        if (result.min_value !== want.min_value) begin
          $error("min_value mismatch: expected %0d, actual %0d",
                 want.min_value, result.min_value);
          failures++;
        end
        if (result.count !== want.count) begin
          $error("count mismatch: expected %0d, actual %0d", want.count, result.count);
          failures++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Reset, then run each test in turn and report.
  initial begin
    failures = 0;
    cycle_count = 0;
    idle_on = 1'b1;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_value_extremes();
    test_equal_minima();
    wait_drained();
    test_full_store();
    idle_on = 1'b1;
    test_random_mix(1600);
    empty_queue();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
